// File: sv/pressure_sensor_temp_compensation_assert.svh
// Assertion macros shared by the compensation block.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef PRESSURE_SENSOR_TEMP_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_TEMP_COMPENSATION_ASSERT_SVH

`ifndef SYNTH

// Expression holds at every edge outside reset
`define PTC_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("ptc assertion failed");

// Antecedent implies consequent in the same cycle
`define PTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptc assertion failed");

// Antecedent implies consequent in the next cycle
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptc assertion failed");

`else

`define PTC_ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define PTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/ptc_pkg.sv
package ptc_pkg;

	// Field and register widths
	localparam int RAW_W  = 16;
	localparam int CAL_W  = 16;
	localparam int TEMP_W = 24;

	// Datapath widths
	localparam int DIFF_W    = RAW_W + 1;           // raw - offset
	localparam int PROD_W    = 2 * DIFF_W;          // signed diff times unsigned gain
	localparam int X1_SHIFT  = 15;
	localparam int X1_W      = 18;                  // |x1| < 2^17
	localparam int DIVR_W    = 19;                  // x1 + denominator
	localparam int NUM_SHIFT = 11;
	localparam int NUM_W     = CAL_W + NUM_SHIFT;   // numerator << 11
	localparam int QUO_W     = NUM_W;               // quotient magnitude
	localparam int REM_W     = DIVR_W + 1;
	localparam int SUM_W     = QUO_W + 1;
	localparam int ROUND_BIAS = 8;
	localparam int OUT_SHIFT  = 4;
	localparam int CNT_W      = $clog2(QUO_W + 1);

	// Calibration register indexes
	typedef enum logic [1:0] {
		REG_OFFSET_SCALE = 2'd0,
		REG_OFFSET       = 2'd1,
		REG_NUMERATOR    = 2'd2,
		REG_DENOMINATOR  = 2'd3
	} ptc_reg_idx_t;

	// Reset values of the calibration registers
	localparam logic [CAL_W-1:0]        RST_OFFSET_SCALE = 16'd32757;
	localparam logic [CAL_W-1:0]        RST_OFFSET       = 16'd23153;
	localparam logic signed [CAL_W-1:0] RST_NUMERATOR    = -16'sd8711;
	localparam logic signed [CAL_W-1:0] RST_DENOMINATOR  = 16'sd2868;

	// Divider sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} ptc_state_t;

	// Item handed from the front part to the divider
	typedef struct packed {
		logic signed [X1_W-1:0]   x1;
		logic signed [DIVR_W-1:0] divisor;
		logic                     div_zero;
	} ptc_item_t;

	// Queue status seen by the producer and the consumer
	typedef struct packed {
		logic empty;
		logic full;
	} ptc_q_status_t;

endpackage

// File: sv/pressure_sensor_temp_compensation.sv
// Path from input accept to result valid when nothing stalls: front stages s1 to s3,
// queue write, divider load, 27 divide steps (none for a zero divisor), result load.
// The divider takes one item at a time at one quotient bit per cycle; the front
// pipeline and queue keep accepting while it is busy, until the queue is full.
// Reset (arst_n low, asynchronous): pipeline and queue empty, calibration
// registers return to their default values.
module pressure_sensor_temp_compensation import ptc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CAL_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [RAW_W-1:0]         raw_temperature,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TEMP_W-1:0] temperature_tenths,
	output logic                     divide_error
);

	logic [CAL_W-1:0]        cal_offset_scale_q;
	logic [CAL_W-1:0]        cal_offset_q;
	logic signed [CAL_W-1:0] cal_numerator_q;
	logic signed [CAL_W-1:0] cal_denominator_q;

	logic          push, pop;
	ptc_item_t     push_item, pop_item;
	ptc_q_status_t q_status;

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_offset_scale_q <= RST_OFFSET_SCALE;
			cal_offset_q       <= RST_OFFSET;
			cal_numerator_q    <= RST_NUMERATOR;
			cal_denominator_q  <= RST_DENOMINATOR;
		end else if (cfg_we) begin
			unique case (ptc_reg_idx_t'(cfg_index))
				REG_OFFSET_SCALE: cal_offset_scale_q <= cfg_wdata;
				REG_OFFSET:       cal_offset_q       <= cfg_wdata;
				REG_NUMERATOR:    cal_numerator_q    <= $signed(cfg_wdata);
				REG_DENOMINATOR:  cal_denominator_q  <= $signed(cfg_wdata);
			endcase
		end
	end

	ptc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.raw_temperature  (raw_temperature),
		.cal_offset_scale (cal_offset_scale_q),
		.cal_offset       (cal_offset_q),
		.cal_denominator  (cal_denominator_q),
		.push             (push),
		.push_item        (push_item),
		.q_status         (q_status)
	);

	ptc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	ptc_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_status           (q_status),
		.pop_item           (pop_item),
		.pop                (pop),
		.cal_numerator      (cal_numerator_q),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.temperature_tenths (temperature_tenths),
		.divide_error       (divide_error)
	);

endmodule

// File: sv/ptc_front.sv
module ptc_front import ptc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [RAW_W-1:0]        raw_temperature,
	input  logic [CAL_W-1:0]        cal_offset_scale,
	input  logic [CAL_W-1:0]        cal_offset,
	input  logic signed [CAL_W-1:0] cal_denominator,
	output logic                    push,
	output ptc_item_t               push_item,
	input  ptc_q_status_t           q_status
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [X1_W-1:0]   x1_s2;
	ptc_item_t                item_s3;
	logic                     en1, en2, en3;

	logic signed [PROD_W-1:0] prod;
	logic signed [DIVR_W-1:0] divisor;

	// Stage enables: a stage moves when it is empty or its successor moves
	assign en3      = !valid_s3 || !q_status.full;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;
	assign push     = valid_s3 && !q_status.full;
	assign push_item = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// Gain multiply, then arithmetic shift right
	assign prod = diff_s1 * $signed({1'b0, cal_offset_scale});

	// Divisor and zero classification
	assign divisor = {x1_s2[X1_W-1], x1_s2}
		+ {{(DIVR_W-CAL_W){cal_denominator[CAL_W-1]}}, cal_denominator};

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			diff_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal_offset});
		end
		if (en2 && valid_s1) begin
			x1_s2 <= prod[X1_SHIFT+X1_W-1:X1_SHIFT];
		end
		if (en3 && valid_s2) begin
			item_s3.x1       <= x1_s2;
			item_s3.divisor  <= divisor;
			item_s3.div_zero <= (divisor == '0);
		end
	end

endmodule

// File: sv/ptc_queue.sv
`include "pressure_sensor_temp_compensation_assert.svh"

module ptc_queue import ptc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptc_item_t     push_item,
	input  logic          pop,
	output ptc_item_t     pop_item,
	output ptc_q_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_QW = $clog2(DEPTH + 1);

	ptc_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_QW'(DEPTH));
	assign pop_item     = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	`PTC_ASSERT_HOLDS(a_count_range, clk, arst_n, count_q <= CNT_QW'(DEPTH))
	`PTC_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`PTC_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, count_q != CNT_QW'(DEPTH) || pop)

endmodule

// File: sv/ptc_back.sv
`include "pressure_sensor_temp_compensation_assert.svh"

module ptc_back import ptc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ptc_q_status_t           q_status,
	input  ptc_item_t               pop_item,
	output logic                    pop,
	input  logic signed [CAL_W-1:0] cal_numerator,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [TEMP_W-1:0] temperature_tenths,
	output logic                    divide_error
);

	ptc_state_t st_q, st_d;
	logic [CNT_W-1:0] cnt_q;

	// Divider registers
	logic [QUO_W-1:0]       num_q;      // numerator shifting out, quotient shifting in
	logic [DIVR_W-1:0]      den_q;
	logic [REM_W-1:0]       rem_q;
	logic signed [X1_W-1:0] x1_q;
	logic                   neg_q;
	logic                   err_q;

	// Output register
	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] temperature_tenths_q;
	logic                     divide_error_q;

	logic load_out, step, out_free;

	logic signed [NUM_W-1:0] numer;
	logic [QUO_W-1:0]        numer_mag;
	logic [DIVR_W-1:0]       divisor_mag;
	logic [REM_W-1:0]        rem_sh;
	logic                    ge;
	logic [SUM_W-1:0]        q_ext, x2, sum;

	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!q_status.empty) st_d = pop_item.div_zero ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(1)) st_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) st_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pop      = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			ST_IDLE: pop      = !q_status.empty;
			ST_DIV:  step     = 1'b1;
			ST_DONE: load_out = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (pop) cnt_q <= CNT_W'(QUO_W);
			else if (step) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Operand magnitudes at load
	assign numer       = {cal_numerator, {NUM_SHIFT{1'b0}}};
	assign numer_mag   = numer[NUM_W-1] ? QUO_W'(-numer) : QUO_W'(numer);
	assign divisor_mag = pop_item.divisor[DIVR_W-1] ? DIVR_W'(-pop_item.divisor)
		: DIVR_W'(pop_item.divisor);

	// One restoring division step per cycle while in the divide state
	assign rem_sh = {rem_q[REM_W-2:0], num_q[QUO_W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q <= numer_mag;
			den_q <= divisor_mag;
			rem_q <= '0;
			x1_q  <= pop_item.x1;
			neg_q <= numer[NUM_W-1] ^ pop_item.divisor[DIVR_W-1];
			err_q <= pop_item.div_zero;
		end else if (step) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			num_q <= {num_q[QUO_W-2:0], ge};
		end
	end

	// Signed quotient plus x1, rounding bias, shift down by four
	assign q_ext = {1'b0, num_q};
	assign x2    = neg_q ? -q_ext : q_ext;
	assign sum   = {{(SUM_W-X1_W){x1_q[X1_W-1]}}, x1_q} + x2 + SUM_W'(ROUND_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			temperature_tenths_q <= err_q ? '0 : $signed(sum[SUM_W-1:OUT_SHIFT]);
			divide_error_q       <= err_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign temperature_tenths = temperature_tenths_q;
	assign divide_error       = divide_error_q;

	`PTC_ASSERT_IMPL(a_div_cnt_live, clk, arst_n, st_q == ST_DIV, cnt_q != '0)
	`PTC_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid_q && divide_error_q,
		temperature_tenths_q == '0)
	`PTC_ASSERT_NEXT(a_pop_leaves_idle, clk, arst_n, pop, st_q != ST_IDLE)

endmodule

// File: tb/tb_pressure_sensor_temp_compensation.sv
module tb_pressure_sensor_temp_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	import ptc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 19;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	// One compensated reading as the block returns it
	typedef struct packed {
		logic signed [TEMP_W-1:0] tenths;
		logic                     div_err;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [1:0]               cfg_index = '0;
	logic [CAL_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [RAW_W-1:0]         raw_temperature = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic                     divide_error;

	// Calibration as the block should hold it
	logic [CAL_W-1:0]        cal_scale = RST_OFFSET_SCALE;
	logic [CAL_W-1:0]        cal_off   = RST_OFFSET;
	logic signed [CAL_W-1:0] cal_num   = RST_NUMERATOR;
	logic signed [CAL_W-1:0] cal_den   = RST_DENOMINATOR;

	reading_t expected_readings[$];

	int  cycle_count = 0;
	int  mismatches = 0;
	int  readings_sent = 0;
	int  div_errors_sent = 0;
	int  cal_settings = 0;
	bit  src_idle = 1'b1;
	bit  sink_idle = 1'b1;
	int  hold_seq = 0;
	int  hold_taken = 0;
	int  hold_len = 0;
	int  stall_left = 0;

	pressure_sensor_temp_compensation u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.raw_temperature    (raw_temperature),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.temperature_tenths (temperature_tenths),
		.divide_error       (divide_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d readings outstanding",
				cycle_count, expected_readings.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offset-corrected, scaled raw value
	function automatic longint calc_x1(logic [RAW_W-1:0] raw);
		longint diff;
		diff = longint'(raw) - longint'(cal_off);
		return (diff * longint'(cal_scale)) >>> X1_SHIFT;
	endfunction

	function automatic reading_t predict_reading(logic [RAW_W-1:0] raw);
		longint x1, divisor, numer, x2, t;
		reading_t r;
		x1 = calc_x1(raw);
		divisor = x1 + longint'(cal_den);
		if (divisor == 0) begin
			r.tenths = '0;
			r.div_err = 1'b1;
		end else begin
			numer = longint'(cal_num) * (longint'(1) << NUM_SHIFT);
			x2 = numer / divisor;
			t = (x1 + x2 + ROUND_BIAS) >>> OUT_SHIFT;
			r.tenths = t[TEMP_W-1:0];
			r.div_err = 1'b0;
		end
		return r;
	endfunction

	// x1 rises with raw, so a binary search finds the raw that zeroes the divisor
	function automatic logic find_zero_raw(output logic [RAW_W-1:0] raw);
		int lo, hi, mid;
		longint target;
		target = -longint'(cal_den);
		lo = 0;
		hi = 65535;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (calc_x1(RAW_W'(mid)) < target)
				lo = mid + 1;
			else
				hi = mid;
		end
		raw = RAW_W'(lo);
		return calc_x1(raw) == target;
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		logic [RAW_W-1:0] raw;
		case ($urandom_range(0, 15))
			0: raw = '0;
			1: raw = '1;
			2: raw = cal_off;
			3: begin
				if (!find_zero_raw(raw))
					raw = RAW_W'($urandom_range(0, 65535));
			end
			default: raw = RAW_W'($urandom_range(0, 65535));
		endcase
		return raw;
	endfunction

	function automatic logic [CAL_W-1:0] pick_cal_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return CAL_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Sender side: one item per call, valid kept high when no gap follows
	task automatic send_reading(input logic [RAW_W-1:0] raw);
		int gap;
		reading_t r;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= raw;
		do @(posedge clk); while (in_stall);
		r = predict_reading(raw);
		expected_readings.push_back(r);
		readings_sent++;
		if (r.div_err)
			div_errors_sent++;
	endtask

	// Drop valid and wait until every reading is back and the block is quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges
	task automatic set_calibration(input logic [CAL_W-1:0] scale, input logic [CAL_W-1:0] off,
			input logic [CAL_W-1:0] num, input logic [CAL_W-1:0] den);
		logic [CAL_W-1:0] words[4];
		ptc_reg_idx_t idx;
		settle_block();
		words = '{scale, off, num, den};
		for (int i = 0; i < 4; i++) begin
			idx = ptc_reg_idx_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= words[i];
			@(posedge clk);
			case (idx)
				REG_OFFSET_SCALE: cal_scale = words[i];
				REG_OFFSET:       cal_off = words[i];
				REG_NUMERATOR:    cal_num = words[i];
				REG_DENOMINATOR:  cal_den = words[i];
			endcase
		end
		cfg_we <= 1'b0;
		cal_settings++;
	endtask

	// Receiver side: random stalls after each item and at random phases,
	// plus a long hold-off on request
	always @(posedge clk) begin : sink_ctl
		int stall_draw;
		if (hold_seq != hold_taken) begin
			hold_taken <= hold_seq;
			stall_left <= hold_len;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			stall_draw = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
			stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
			out_stall <= (stall_draw > 0);
		end else if (sink_idle && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, MAX_GAP);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected result: tenths %0d err %0b", $realtime,
						temperature_tenths, divide_error);
			end else begin
				want = expected_readings.pop_front();
				if (temperature_tenths !== want.tenths || divide_error !== want.div_err) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("[%0t] mismatch: tenths exp %0d got %0d, err exp %0b got %0b",
							$realtime, want.tenths, temperature_tenths, want.div_err,
							divide_error);
				end
			end
		end
	end

	// Reset values of the calibration, typical and extreme raw words
	task automatic test_default_calibration();
		send_reading(16'd0);
		send_reading(16'hFFFF);
		send_reading(RST_OFFSET);
		send_reading(16'd27898);
	endtask

	// Divisor exactly zero, and divisors of one on either side
	task automatic test_zero_divisor();
		set_calibration(16'd32768, 16'd0, 16'h8000, -16'sd1000);
		send_reading(16'd1000);
		send_reading(16'd999);
		send_reading(16'd1001);
		// no gain and no denominator: every reading is a divide error
		set_calibration(16'd0, 16'd12345, 16'h7FFF, 16'd0);
		send_reading(16'd0);
		send_reading(16'hFFFF);
	endtask

	// Register and field extremes
	task automatic test_field_extremes();
		set_calibration(16'hFFFF, 16'd0, 16'h7FFF, 16'h8000);
		send_reading(16'd0);
		send_reading(16'hFFFF);
		send_reading(16'h8000);
		set_calibration(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
		send_reading(16'd0);
		send_reading(16'hFFFF);
		set_calibration(16'd1, 16'h8000, 16'h7FFF, 16'd1);
		send_reading(16'h5555);
		send_reading(16'hAAAA);
	endtask

	// Long receiver hold-off while the sender streams at full rate
	task automatic test_output_holdoff();
		set_calibration(RST_OFFSET_SCALE, RST_OFFSET, RST_NUMERATOR, RST_DENOMINATOR);
		src_idle = 1'b0;
		hold_len <= HOLD_CYCLES;
		hold_seq <= hold_seq + 1;
		repeat (16) send_reading(RAW_W'($urandom_range(0, 65535)));
		settle_block();
		src_idle = 1'b1;
	endtask

	// Random readings over a sequence of calibration settings
	task automatic test_random_readings();
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0)
				set_calibration(RST_OFFSET_SCALE, RST_OFFSET, RST_NUMERATOR,
					RST_DENOMINATOR);
			else if (phase == 1)
				set_calibration(16'd32768, CAL_W'($urandom_range(0, 65535)),
					pick_cal_word(), pick_cal_word());
			else
				set_calibration(pick_cal_word(), pick_cal_word(), pick_cal_word(),
					pick_cal_word());
			src_idle = (phase % 3 != 2);
			sink_idle = (phase % 3 != 2);
			for (int k = 0; k < 110; k++) begin
				// sender pause mid-phase until everything is back
				if (phase == 5 && k == 55)
					settle_block();
				send_reading(pick_raw());
			end
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_calibration();
		test_zero_divisor();
		test_field_extremes();
		test_output_holdoff();
		test_random_readings();
		settle_block();

		$display("Sent %0d raw readings (%0d zero-divisor cases) over %0d calibration settings",
			readings_sent, div_errors_sent, cal_settings);
		$display("Mismatches: %0d, readings still outstanding: %0d", mismatches,
			expected_readings.size());
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
